[src/b2sd_pkg.sv]
// ----------------------------------------------------------------------------
// b2sd_pkg
// Shared types, constants and helper functions for the binary to signed
// decimal converter.
// ----------------------------------------------------------------------------
`default_nettype none

package b2sd_pkg;

  localparam int ValueBitsDefault = 128;
  localparam int HalfW = 64;
  localparam int DigitW = 4;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StEmit
  } b2sd_state_e;

  typedef struct packed {
    logic load;
    logic conv;
    logic emit;
  } b2sd_ctrl_t;

  // Number of decimal digits needed for any value of the given bit width.
  function automatic int num_digits(input int bits);
    num_digits = (bits * 30103) / 100000 + 1;
  endfunction

endpackage

`default_nettype wire

[src/b2sd_if.sv]
// ----------------------------------------------------------------------------
// b2sd_if
// Valid/ready channels for the binary value requests and the digit results.
// ----------------------------------------------------------------------------
`default_nettype none

interface b2sd_in_if
  import b2sd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [HalfW-1:0]  value_high;
  logic [HalfW-1:0]  value_low;
  logic              as_signed;

  modport source (output valid, output value_high, output value_low, output as_signed,
                  input ready);
  modport sink (input valid, input value_high, input value_low, input as_signed,
                output ready);
endinterface

interface b2sd_out_if
  import b2sd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DigitW-1:0] digit;
  logic              negative;
  logic              last;

  modport source (output valid, output digit, output negative, output last, input ready);
  modport sink (input valid, input digit, input negative, input last, output ready);
endinterface

`default_nettype wire

[src/b2sd_dabble.sv]
// ----------------------------------------------------------------------------
// b2sd_dabble
// Magnitude register and BCD register with one shift-and-add-3 step per
// cycle, then a digit shifter that presents the most significant digit.
// ----------------------------------------------------------------------------
`default_nettype none

module b2sd_dabble
  import b2sd_pkg::*;
#(
  parameter int VALUE_BITS = ValueBitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire b2sd_ctrl_t        ctrl_i,
  input  wire logic [HalfW-1:0]  value_high_i,
  input  wire logic [HalfW-1:0]  value_low_i,
  input  wire logic              as_signed_i,
  output logic [DigitW-1:0]      top_digit_o,
  output logic                   negative_o
);

  localparam int NDigits = num_digits(VALUE_BITS);
  localparam int BcdW = NDigits * DigitW;

  logic [2*HalfW-1:0]    full_value;
  logic [VALUE_BITS-1:0] value;
  logic [VALUE_BITS-1:0] magnitude;
  logic                  is_neg;
  logic                  is_min;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BcdW-1:0]       bcd_q, bcd_d;
  logic [BcdW-1:0]       bcd_adj;
  logic                  neg_q, neg_d;

  assign full_value = {value_high_i, value_low_i};
  assign value = full_value[VALUE_BITS-1:0];
  assign magnitude = ~value + VALUE_BITS'(1);
  assign is_neg = as_signed_i && value[VALUE_BITS-1];
  assign is_min = (value == {1'b1, {(VALUE_BITS-1){1'b0}}});

  always_comb begin
    for (int i = 0; i < NDigits; i++) begin
      if (bcd_q[i*DigitW +: DigitW] >= DigitW'(5)) begin
        bcd_adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW] + DigitW'(3);
      end else begin
        bcd_adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW];
      end
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    neg_d = neg_q;
    if (ctrl_i.load) begin
      bcd_d = '0;
      if (is_neg && is_min) begin
        bin_d = '0;
        neg_d = 1'b0;
      end else if (is_neg) begin
        bin_d = magnitude;
        neg_d = 1'b1;
      end else begin
        bin_d = value;
        neg_d = 1'b0;
      end
    end else if (ctrl_i.conv) begin
      bcd_d = {bcd_adj[BcdW-2:0], bin_q[VALUE_BITS-1]};
      bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
    end else if (ctrl_i.emit) begin
      bcd_d = {bcd_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q <= '0;
      bcd_q <= '0;
      neg_q <= 1'b0;
    end else begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
      neg_q <= neg_d;
    end
  end

  assign top_digit_o = bcd_q[BcdW-1 -: DigitW];
  assign negative_o = neg_q;

endmodule

`default_nettype wire

[src/b2sd_seq.sv]
// ----------------------------------------------------------------------------
// b2sd_seq
// Sequencer for the conversion steps and the digit output, with the result
// register that feeds the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module b2sd_seq
  import b2sd_pkg::*;
#(
  parameter int VALUE_BITS = ValueBitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [DigitW-1:0]      out_digit_o,
  output logic                   out_negative_o,
  output logic                   out_last_o,
  input  wire logic [DigitW-1:0] top_digit_i,
  input  wire logic              negative_i,
  output b2sd_ctrl_t             ctrl_o
);

  localparam int NDigits = num_digits(VALUE_BITS);
  localparam int CntW = $clog2(VALUE_BITS);

  b2sd_state_e       state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              started_q, started_d;
  logic              out_valid_q, out_valid_d;
  logic [DigitW-1:0] out_digit_q, out_digit_d;
  logic              out_neg_q, out_neg_d;
  logic              out_last_q, out_last_d;
  logic              out_free;
  logic              cnt_zero;
  logic              push;

  assign out_free = !out_valid_q || out_ready_i;
  assign cnt_zero = (cnt_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StConv;
        end
      end
      StConv: begin
        if (cnt_zero) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free && cnt_zero) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    ctrl_o = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      StConv: ctrl_o.conv = 1'b1;
      StEmit: ctrl_o.emit = out_free;
      default: ctrl_o = '0;
    endcase
  end

  assign push = ctrl_o.emit && (started_q || (top_digit_i != '0) || cnt_zero);

  always_comb begin
    cnt_d = cnt_q;
    started_d = started_q;
    if (ctrl_o.load) begin
      cnt_d = CntW'(VALUE_BITS - 1);
      started_d = 1'b0;
    end else if (ctrl_o.conv) begin
      cnt_d = cnt_zero ? CntW'(NDigits - 1) : cnt_q - CntW'(1);
    end else if (ctrl_o.emit) begin
      if (!cnt_zero) begin
        cnt_d = cnt_q - CntW'(1);
      end
      if (top_digit_i != '0) begin
        started_d = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_digit_d = out_digit_q;
    out_neg_d = out_neg_q;
    out_last_d = out_last_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_digit_d = top_digit_i;
      out_neg_d = negative_i;
      out_last_d = cnt_zero;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      started_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      started_q <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_digit_q <= out_digit_d;
    out_neg_q <= out_neg_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_digit_o = out_digit_q;
  assign out_negative_o = out_neg_q;
  assign out_last_o = out_last_q;

endmodule

`default_nettype wire

[src/binary_to_signed_decimal_128.sv]
// ----------------------------------------------------------------------------
// binary_to_signed_decimal_128
// Converts a binary value, unsigned or two's complement, into a stream of
// decimal digits with sign and last marker.
// ----------------------------------------------------------------------------
//   Channel  Dir  Carries
//   in_i     in   value_high, value_low, as_signed: one request per number
//   out_o    out  digit, negative, last: one result per decimal digit
//
// A request is loaded, converted by shift-and-add-3 in the BCD register
// over every bit of the value, then shifted out one digit position at a
// time (leading zeros are skipped but still take their turn).
// The BCD register is the single shared unit and holds one request at a time.
// A stalled output holds the sequencer in place; a new request is taken as
// soon as the last digit sits in the result register.
// Reset clears the sequencer and the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_signed_decimal_128
  import b2sd_pkg::*;
#(
  parameter int VALUE_BITS = ValueBitsDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  b2sd_in_if.sink    in_i,
  b2sd_out_if.source out_o
);

  b2sd_ctrl_t        ctrl;
  logic [DigitW-1:0] top_digit;
  logic              negative;

  b2sd_dabble #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dabble (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .value_high_i (in_i.value_high),
    .value_low_i  (in_i.value_low),
    .as_signed_i  (in_i.as_signed),
    .top_digit_o  (top_digit),
    .negative_o   (negative)
  );

  b2sd_seq #(
    .VALUE_BITS(VALUE_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_digit_o    (out_o.digit),
    .out_negative_o (out_o.negative),
    .out_last_o     (out_o.last),
    .top_digit_i    (top_digit),
    .negative_i     (negative),
    .ctrl_o         (ctrl)
  );

endmodule

`default_nettype wire

[test/binary_to_signed_decimal_128_tb.sv]
// ----------------------------------------------------------------------------
// binary_to_signed_decimal_128_tb
// Sends 128-bit numbers, read unsigned or as two's complement, through the
// converter and checks every decimal digit that comes back. The check covers
// the digit, the sign flag and the last marker. A short table of edge values
// comes first, then randomly built numbers. The sender works in bursts, the
// receiver stalls on its own pattern, and twice it holds off long enough for
// the converter to back up onto its input.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_signed_decimal_128_tb;
  import b2sd_pkg::*;

  localparam int ValueBits = ValueBitsDefault;
  localparam int WideW = 2 * HalfW;
  localparam int RandomNumbers = 470;
  localparam int LongHold = 800;
  localparam int DrainCycles = 200;
  localparam int MaxReports = 10;
  localparam byte AsciiZero = 8'd48;
  localparam int DirRows = 19;
  localparam bit [WideW-1:0] TenPow38 = 128'h4B3B4CA8_5A86C47A_098A2240_00000000;

  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic              negative;
    logic              last;
  } digit_res_t;

  typedef enum int {
    RxFull,
    RxCoin,
    RxSparse,
    RxCadence
  } rx_mode_e;

  logic clk;
  logic rst_n;

  b2sd_in_if  in_if ();
  b2sd_out_if out_if ();

  binary_to_signed_decimal_128 dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Rows with an empty digit string are checked against the predictor.
  bit [WideW-1:0] dir_value [DirRows] = '{
    128'd0,
    128'd0,
    128'd1,
    128'd9,
    128'd10,
    {WideW{1'b1}},
    {WideW{1'b1}},
    {1'b1, {(WideW-1){1'b0}}},
    {1'b1, {(WideW-1){1'b0}}},
    {1'b0, {(WideW-1){1'b1}}},
    {1'b1, {(WideW-2){1'b0}}, 1'b1},
    {64'd0, 64'hFFFF_FFFF_FFFF_FFFF},
    {64'd1, 64'd0},
    TenPow38 - 128'd1,
    TenPow38,
    128'd0 - 128'd12345,
    {64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555},
    {64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555},
    {64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA}
  };
  bit dir_signed [DirRows] = '{0, 1, 0, 1, 0, 0, 1, 1, 0, 1, 1, 0, 1, 0, 1, 1, 0, 1, 1};
  bit dir_neg [DirRows] = '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0};
  string dir_digits [DirRows] = '{
    "0",
    "0",
    "1",
    "9",
    "10",
    "340282366920938463463374607431768211455",
    "1",
    "0",
    "170141183460469231731687303715884105728",
    "170141183460469231731687303715884105727",
    "170141183460469231731687303715884105727",
    "18446744073709551615",
    "18446744073709551616",
    "",
    "",
    "",
    "",
    "",
    ""
  };

  digit_res_t expected_digits[$];
  int mismatches;
  int hold_offs_requested;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void queue_digit(input logic [DigitW-1:0] d, input bit neg,
                                      input bit last);
    digit_res_t r;
    r.digit = d;
    r.negative = neg;
    r.last = last;
    expected_digits.insert(expected_digits.size(), r);
  endfunction

  function automatic void predict_digits(input bit [WideW-1:0] raw_in, input bit sgn);
    bit [WideW-1:0] mask;
    bit [WideW-1:0] raw;
    bit [WideW-1:0] mag;
    bit neg;
    bit [DigitW-1:0] digs[$];
    mask = (ValueBits >= WideW) ? {WideW{1'b1}} : ((WideW'(1) << ValueBits) - 1'b1);
    raw = raw_in & mask;
    mag = raw;
    neg = 1'b0;
    if (sgn && raw[ValueBits-1]) begin
      mag = (~raw + 1'b1) & mask;
      // The most negative value negates to itself and is reported as zero.
      if (mag == raw) begin
        mag = '0;
      end else begin
        neg = 1'b1;
      end
    end
    do begin
      digs.push_front(DigitW'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    foreach (digs[i]) queue_digit(digs[i], neg, i == digs.size() - 1);
  endfunction

  function automatic bit [WideW-1:0] random_number();
    bit [WideW-1:0] v;
    bit [WideW-1:0] p;
    int k;
    case ($urandom_range(0, 7))
      0, 1: v = {$urandom, $urandom, $urandom, $urandom};
      2: v = WideW'($urandom_range(0, 999));
      3: v = 128'd0 - WideW'($urandom_range(1, 100000));
      4: begin
        k = $urandom_range(0, WideW - 1);
        v = (WideW'(1) << k) + WideW'($urandom_range(0, 2)) - 1'b1;
      end
      5: begin
        k = $urandom_range(0, 38);
        p = WideW'(1);
        repeat (k) p = p * 10;
        v = p + WideW'($urandom_range(0, 2)) - 1'b1;
      end
      6: v = {($urandom_range(0, 1) ? {HalfW{1'b1}} : {HalfW{1'b0}}), $urandom, $urandom};
      default: v = {$urandom, $urandom, $urandom, $urandom} >> $urandom_range(0, WideW - 1);
    endcase
    return v;
  endfunction

  task automatic send_number(input bit [WideW-1:0] value, input bit sgn, input string typed,
                             input bit typed_neg);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0: gap = $urandom_range(100, 250);
        1, 2: gap = $urandom_range(10, 40);
        default: gap = $urandom_range(0, 3);
      endcase
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(10, 20) : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.value_high <= value[WideW-1:HalfW];
    in_if.value_low <= value[HalfW-1:0];
    in_if.as_signed <= sgn;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (typed.len() != 0) begin
      for (int i = 0; i < typed.len(); i++) begin
        queue_digit(DigitW'(typed.getc(i) - AsciiZero), typed_neg, i == typed.len() - 1);
      end
    end else begin
      predict_digits(value, sgn);
    end
  endtask

  initial begin : receiver
    rx_mode_e mode;
    int mode_left;
    int hold_left;
    int holds_done;
    int cyc;
    out_if.ready = 1'b0;
    mode = RxFull;
    mode_left = 0;
    hold_left = 0;
    holds_done = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (holds_done != hold_offs_requested) begin
        holds_done++;
        hold_left = LongHold;
      end
      if (mode_left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          RxFull: out_if.ready <= 1'b1;
          RxCoin: out_if.ready <= 1'($urandom_range(0, 1));
          RxSparse: out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= (cyc % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : digit_check
    digit_res_t got;
    digit_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.digit = out_if.digit;
      got.negative = out_if.negative;
      got.last = out_if.last;
      if (expected_digits.size() == 0) begin
        if (mismatches < MaxReports) begin
          $display("unexpected digit %0d negative %0d last %0d", got.digit, got.negative,
                   got.last);
        end
        mismatches++;
      end else begin
        want = expected_digits.pop_front();
        if (got !== want) begin
          if (mismatches < MaxReports) begin
            $display("digit mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d (digit/neg/last)",
                     want.digit, want.negative, want.last, got.digit, got.negative, got.last);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    bit [WideW-1:0] v;
    mismatches = 0;
    hold_offs_requested = 0;
    burst_left = 0;
    in_if.valid = 1'b0;
    in_if.value_high = '0;
    in_if.value_low = '0;
    in_if.as_signed = 1'b0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DirRows; i++) begin
      send_number(dir_value[i], dir_signed[i], dir_digits[i], dir_neg[i]);
    end

    for (int i = 0; i < RandomNumbers; i++) begin
      if (i == 120 || i == 330) hold_offs_requested++;
      v = random_number();
      send_number(v, 1'($urandom_range(0, 1)), "", 1'b0);
    end
    @(negedge clk);
    in_if.valid <= 1'b0;

    while (expected_digits.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
